// ----- hw/rtl/bbc_pkg.sv -----
// Package for the bracket balance checker: shared widths, character and
// status codes, bracket kinds and the structs that pass between the modules.
// Depends on nothing.
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int CHAR_W          = 8;
    localparam int STATUS_W        = 3;
    localparam int COUNT_W         = 7;
    localparam int KIND_W          = 2;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CHAR_W-1:0] CH_ROUND_OPEN   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_ROUND_CLOSE  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_CURLY_OPEN   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CURLY_CLOSE  = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_SQUARE_OPEN  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_SQUARE_CLOSE = 8'h5D;

    localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNCLOSED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    // One classified request as it waits between front and back.
    typedef struct packed {
        logic              is_open;
        logic              is_close;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_op;

    typedef struct packed {
        logic                done_res;
        logic                balanced;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  open_count;
    } t_res;

endpackage

// ----- hw/rtl/bbc_ifs.sv -----
// Valid/ready channel interfaces of the bracket balance checker.
// Depends on bbc_pkg for the field widths.
interface bbc_in_if;
    logic                         valid;
    logic                         ready;
    logic [bbc_pkg::CHAR_W-1:0]   character;
    logic                         last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface bbc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         done_res;
    logic                         balanced;
    logic [bbc_pkg::STATUS_W-1:0] status;
    logic [bbc_pkg::COUNT_W-1:0]  open_count;

    modport source (output valid, output done_res, output balanced, output status,
                    output open_count, input ready);
    modport sink   (input valid, input done_res, input balanced, input status,
                    input open_count, output ready);
endinterface

// ----- hw/rtl/bbc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/bbc_front.sv -----
// Front end: takes characters from the input channel and classifies each one
// as an open, a close or a pass-through. Depends on bbc_pkg and bbc_ifs.
module bbc_front (
    bbc_in_if.sink          i_in,
    input  logic            i_q_ready,
    output logic            o_push,
    output bbc_pkg::t_op    o_op
);

    logic [bbc_pkg::KIND_W-1:0] open_kind;
    logic [bbc_pkg::KIND_W-1:0] close_kind;

    always_comb begin
        unique case (i_in.character)
            bbc_pkg::CH_ROUND_OPEN:  open_kind = bbc_pkg::KIND_ROUND;
            bbc_pkg::CH_CURLY_OPEN:  open_kind = bbc_pkg::KIND_CURLY;
            bbc_pkg::CH_SQUARE_OPEN: open_kind = bbc_pkg::KIND_SQUARE;
            default:                 open_kind = bbc_pkg::KIND_NONE;
        endcase
        unique case (i_in.character)
            bbc_pkg::CH_ROUND_CLOSE:  close_kind = bbc_pkg::KIND_ROUND;
            bbc_pkg::CH_CURLY_CLOSE:  close_kind = bbc_pkg::KIND_CURLY;
            bbc_pkg::CH_SQUARE_CLOSE: close_kind = bbc_pkg::KIND_SQUARE;
            default:                  close_kind = bbc_pkg::KIND_NONE;
        endcase
    end

    always_comb begin
        o_op.is_open  = (open_kind != bbc_pkg::KIND_NONE);
        o_op.is_close = (close_kind != bbc_pkg::KIND_NONE);
        o_op.kind     = o_op.is_open ? open_kind : close_kind;
        o_op.last     = i_in.last;
    end

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

endmodule

// ----- hw/rtl/bbc_queue.sv -----
// Two-entry request queue between the front and the back end.
// Depends on bbc_pkg for the request struct.
module bbc_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  bbc_pkg::t_op i_op,
    output logic         o_ready,
    input  logic         i_pop,
    output logic         o_valid,
    output bbc_pkg::t_op o_op
);

    localparam int PTR_W = $clog2(bbc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(bbc_pkg::QUEUE_DEPTH + 1);

    bbc_pkg::t_op     r_slot [bbc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_ready = (r_count != CNT_W'(bbc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ----- hw/rtl/bbc_back.sv -----
// Back end: runs the bracket stack and the sticky error, and holds each
// result in an output register. Depends on bbc_pkg, bbc_ifs and bbc_ram.
module bbc_back #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  bbc_pkg::t_op  i_op,
    output logic          o_q_pop,
    bbc_out_if.source     o_out
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0]                r_depth;
    logic [DW-1:0]                n_depth;
    logic [bbc_pkg::STATUS_W-1:0] r_err;
    logic [bbc_pkg::STATUS_W-1:0] n_err;
    logic [bbc_pkg::KIND_W-1:0]   r_top;
    logic [bbc_pkg::KIND_W-1:0]   n_top;
    logic                         r_out_valid;
    bbc_pkg::t_res                r_out;
    bbc_pkg::t_res                n_out;
    logic                         fire;
    logic                         we;
    logic [bbc_pkg::KIND_W-1:0]   below_top;
    logic [DW-1:0]                rd_index;

    assign fire    = i_q_valid && (!r_out_valid || o_out.ready);
    assign o_q_pop = fire;

    // The top entry lives in r_top. The RAM is read every cycle at the entry
    // just below the top, so a pop has the new top ready on the next cycle.
    assign rd_index = n_depth - DW'(2);

    bbc_ram #(
        .WIDTH (bbc_pkg::KIND_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_depth[AW-1:0]),
        .i_wdata (i_op.kind),
        .i_raddr (rd_index[AW-1:0]),
        .o_rdata (below_top)
    );

    always_comb begin
        n_depth = r_depth;
        n_err   = r_err;
        n_top   = r_top;
        we      = 1'b0;
        n_out   = '0;
        if (fire) begin
            if (r_err == bbc_pkg::ST_OK) begin
                if (i_op.is_open) begin
                    if (r_depth >= DW'(STACK_DEPTH)) begin
                        n_err = bbc_pkg::ST_OVERFLOW;
                    end else begin
                        we      = 1'b1;
                        n_top   = i_op.kind;
                        n_depth = r_depth + 1'b1;
                    end
                end else if (i_op.is_close) begin
                    if (r_depth == '0) begin
                        n_err = bbc_pkg::ST_EMPTY;
                    end else begin
                        n_depth = r_depth - 1'b1;
                        n_top   = below_top;
                        if (r_top != i_op.kind) begin
                            n_err = bbc_pkg::ST_MISMATCH;
                        end
                    end
                end
            end
            n_out.status     = n_err;
            n_out.open_count = bbc_pkg::COUNT_W'(n_depth);
            if (i_op.last) begin
                n_out.done_res = 1'b1;
                if (n_err != bbc_pkg::ST_OK) begin
                    n_out.status = n_err;
                end else if (n_depth != '0) begin
                    n_out.status = bbc_pkg::ST_UNCLOSED;
                end else begin
                    n_out.status   = bbc_pkg::ST_OK;
                    n_out.balanced = 1'b1;
                end
                n_depth = '0;
                n_err   = bbc_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_err       <= bbc_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_err   <= n_err;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.done_res   = r_out.done_res;
    assign o_out.balanced   = r_out.balanced;
    assign o_out.status     = r_out.status;
    assign o_out.open_count = r_out.open_count;

endmodule

// ----- hw/rtl/bracket_balance_checker.sv -----
// Top level of the bracket balance checker: front end, request queue and
// back end with the stack RAM. Depends on bbc_pkg, bbc_ifs and all bbc_ modules.
//
//   Channel  Dir  Carries                                        Accepted when
//   i_in     in   character[7:0], last                           valid && ready
//   o_out    out  done_res, balanced, status[2:0], open_count    valid && ready
//
// One character per cycle is sustained while the output is not stalled. A result
// passes through a queue slot, then the output register, before it is offered.
// The stack top sits in a register and the RAM's registered read keeps the
// entry below it ready, so consecutive pops need no bubble.
// Reset is synchronous; the stack RAM needs no clearing, so input is taken
// right after reset. A stalled output fills the two-entry queue, then ready drops.
module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bbc_in_if.sink     i_in,
    bbc_out_if.source  o_out
);

    logic         front_push;
    bbc_pkg::t_op front_op;
    logic         q_ready;
    logic         q_valid;
    logic         q_pop;
    bbc_pkg::t_op q_op;

    bbc_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (front_push),
        .o_op      (front_op)
    );

    bbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_op    (front_op),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (q_op),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ----- tb/bracket_balance_checker_tb.sv -----
// Self-checking testbench for bracket_balance_checker: drives character requests,
// predicts every verdict and compares the results field by field.
// Depends on bbc_pkg, bbc_ifs and the bracket_balance_checker RTL.
module bracket_balance_checker_tb;

    localparam int DEPTH       = bbc_pkg::STACK_DEPTH_DEF;
    localparam int PHASE_CHARS = 400;
    localparam int CYCLE_LIMIT = 300000;

    // Predicts the verdict stream and holds the verdicts still to come.
    class bracket_scoreboard;
        logic [bbc_pkg::KIND_W-1:0]   kinds [DEPTH];
        int                           depth;
        logic [bbc_pkg::STATUS_W-1:0] err;
        bbc_pkg::t_res                pending_verdicts [$];
        int                           errors;
        int                           verdicts_seen;
        int                           balanced_seen;
        int                           status_hits [5];

        function new();
            depth  = 0;
            err    = bbc_pkg::ST_OK;
            errors = 0;
            verdicts_seen = 0;
            balanced_seen = 0;
            foreach (kinds[i]) kinds[i] = bbc_pkg::KIND_ROUND;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        static function logic [bbc_pkg::KIND_W-1:0] opening_kind(
            logic [bbc_pkg::CHAR_W-1:0] c);
            case (c)
                bbc_pkg::CH_ROUND_OPEN:  return bbc_pkg::KIND_ROUND;
                bbc_pkg::CH_CURLY_OPEN:  return bbc_pkg::KIND_CURLY;
                bbc_pkg::CH_SQUARE_OPEN: return bbc_pkg::KIND_SQUARE;
                default:                 return bbc_pkg::KIND_NONE;
            endcase
        endfunction

        static function logic [bbc_pkg::KIND_W-1:0] closing_kind(
            logic [bbc_pkg::CHAR_W-1:0] c);
            case (c)
                bbc_pkg::CH_ROUND_CLOSE:  return bbc_pkg::KIND_ROUND;
                bbc_pkg::CH_CURLY_CLOSE:  return bbc_pkg::KIND_CURLY;
                bbc_pkg::CH_SQUARE_CLOSE: return bbc_pkg::KIND_SQUARE;
                default:                  return bbc_pkg::KIND_NONE;
            endcase
        endfunction

        function void note_char(logic [bbc_pkg::CHAR_W-1:0] c, logic is_last);
            logic [bbc_pkg::KIND_W-1:0] ok;
            logic [bbc_pkg::KIND_W-1:0] ck;
            bbc_pkg::t_res v;
            ok = opening_kind(c);
            ck = closing_kind(c);
            // Once an error is set, the rest of the expression is ignored.
            if (err == bbc_pkg::ST_OK) begin
                if (ok != bbc_pkg::KIND_NONE) begin
                    if (depth >= DEPTH) begin
                        err = bbc_pkg::ST_OVERFLOW;
                    end else begin
                        kinds[depth] = ok;
                        depth++;
                    end
                end else if (ck != bbc_pkg::KIND_NONE) begin
                    if (depth == 0) begin
                        err = bbc_pkg::ST_EMPTY;
                    end else begin
                        depth--;
                        if (kinds[depth] != ck) err = bbc_pkg::ST_MISMATCH;
                    end
                end
            end
            v.done_res   = is_last;
            v.balanced   = 1'b0;
            v.status     = err;
            v.open_count = bbc_pkg::COUNT_W'(depth);
            if (is_last) begin
                if (err != bbc_pkg::ST_OK) begin
                    v.status = err;
                end else if (depth != 0) begin
                    v.status = bbc_pkg::ST_UNCLOSED;
                end else begin
                    v.status   = bbc_pkg::ST_OK;
                    v.balanced = 1'b1;
                end
                status_hits[v.status]++;
                depth = 0;
                err   = bbc_pkg::ST_OK;
            end
            pending_verdicts.push_back(v);
        endfunction

        function void check_verdict(bbc_pkg::t_res got);
            bbc_pkg::t_res want;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: done_res %0d status %0d open_count %0d",
                       got.done_res, got.status, got.open_count);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.done_res !== want.done_res) begin
                $error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
                errors++;
            end
            if (got.balanced !== want.balanced) begin
                $error("balanced: expected %0d, actual %0d", want.balanced, got.balanced);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.open_count !== want.open_count) begin
                $error("open_count: expected %0d, actual %0d", want.open_count,
                       got.open_count);
                errors++;
            end
            if (want.done_res) begin
                verdicts_seen++;
                if (want.balanced) balanced_seen++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bbc_in_if  in_ch ();
    bbc_out_if out_ch ();

    bracket_balance_checker #(.STACK_DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bracket_scoreboard board;
    int chars_sent;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_request;
    int hold_left;
    int cycles;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.character = '0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        chars_sent = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        cycles = 0;
        board = new();
    end

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[bracket_balance_checker] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        bbc_pkg::t_res got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.done_res   = out_ch.done_res;
            got.balanced   = out_ch.balanced;
            got.status     = out_ch.status;
            got.open_count = out_ch.open_count;
            board.check_verdict(got);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(logic [bbc_pkg::CHAR_W-1:0] c, logic is_last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.character <= c;
        in_ch.last      <= is_last;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_char(c, is_last);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [bbc_pkg::CHAR_W-1:0] open_char(
        logic [bbc_pkg::KIND_W-1:0] k);
        case (k)
            bbc_pkg::KIND_ROUND: return bbc_pkg::CH_ROUND_OPEN;
            bbc_pkg::KIND_CURLY: return bbc_pkg::CH_CURLY_OPEN;
            default:             return bbc_pkg::CH_SQUARE_OPEN;
        endcase
    endfunction

    function automatic logic [bbc_pkg::CHAR_W-1:0] close_char(
        logic [bbc_pkg::KIND_W-1:0] k);
        case (k)
            bbc_pkg::KIND_ROUND: return bbc_pkg::CH_ROUND_CLOSE;
            bbc_pkg::KIND_CURLY: return bbc_pkg::CH_CURLY_CLOSE;
            default:             return bbc_pkg::CH_SQUARE_CLOSE;
        endcase
    endfunction

    function automatic logic [bbc_pkg::CHAR_W-1:0] random_filler();
        logic [bbc_pkg::CHAR_W-1:0] c;
        do c = bbc_pkg::CHAR_W'($urandom_range(0, 255));
        while (bracket_scoreboard::opening_kind(c) != bbc_pkg::KIND_NONE ||
               bracket_scoreboard::closing_kind(c) != bbc_pkg::KIND_NONE);
        return c;
    endfunction

    function automatic logic [bbc_pkg::KIND_W-1:0] random_kind();
        return bbc_pkg::KIND_W'($urandom_range(0, 2));
    endfunction

    // Mostly well-formed expressions with random content; the rest are deep
    // nests around the stack limit, corrupted expressions and raw noise.
    task automatic random_expression();
        logic [bbc_pkg::CHAR_W-1:0] text [$];
        logic [bbc_pkg::KIND_W-1:0] open_kinds [$];
        int pick;
        int len;
        int max_nest;
        int r;
        bit noisy;
        pick = $urandom_range(0, 99);
        noisy = 1'b0;
        if (pick < 6) begin
            len = $urandom_range(DEPTH - 4, DEPTH + 4);
            for (int i = 0; i < len; i++) begin
                open_kinds.push_back(random_kind());
                text.push_back(open_char(open_kinds[$]));
                if ($urandom_range(0, 9) == 0) text.push_back(random_filler());
            end
            while (open_kinds.size() > 0) text.push_back(close_char(open_kinds.pop_back()));
        end else if (pick < 85) begin
            len = $urandom_range(1, 14);
            max_nest = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 2);
                if (r == 0 && open_kinds.size() < max_nest) begin
                    open_kinds.push_back(random_kind());
                    text.push_back(open_char(open_kinds[$]));
                end else if (r == 1 && open_kinds.size() > 0) begin
                    text.push_back(close_char(open_kinds.pop_back()));
                end else begin
                    text.push_back(random_filler());
                end
            end
            while (open_kinds.size() > 0) text.push_back(close_char(open_kinds.pop_back()));
            if (pick >= 65) begin
                case ($urandom_range(0, 2))
                    0: text[$urandom_range(0, text.size() - 1)] =
                           ($urandom_range(0, 1) == 1) ? close_char(random_kind())
                                                       : open_char(random_kind());
                    1: void'(text.pop_back());
                    default: text.push_front(close_char(random_kind()));
                endcase
            end
        end else begin
            noisy = 1'b1;
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 1) == 1) begin
                    text.push_back(($urandom_range(0, 1) == 1) ? close_char(random_kind())
                                                               : open_char(random_kind()));
                end else begin
                    text.push_back(bbc_pkg::CHAR_W'($urandom_range(0, 255)));
                end
            end
        end
        if (text.size() == 0) text.push_back(random_filler());
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], (i == text.size() - 1) || (noisy && $urandom_range(0, 5) == 0));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: plain pairs, nesting, close on empty, mismatch with
        // ignored tail, character extremes and an unclosed expression.
        send_text("()");
        send_text("{[]}");
        send_text("]");
        send_text("(]x(");
        send_text("{)");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(bbc_pkg::CH_SQUARE_OPEN, 1'b1);
        send_text("A");
        send_text("[}]]");

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 72; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 72; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            // Long receiver hold-off while requests keep coming, to fill the queue.
            if (phase == 0) hold_request = 60;
            while (chars_sent < (phase + 1) * PHASE_CHARS) random_expression();
        end
        in_ch.valid <= 1'b0;
        rx_stall_pct = 0;

        while (board.pending_verdicts.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        board.errors += board.pending_verdicts.size();

        $display("Summary: %0d characters in four handshake phases, %0d verdicts, %0d balanced.",
                 chars_sent, board.verdicts_seen, board.balanced_seen);
        $display("Verdicts by status: mismatch %0d, close on empty %0d, unclosed %0d, overflow %0d.",
                 board.status_hits[bbc_pkg::ST_MISMATCH], board.status_hits[bbc_pkg::ST_EMPTY],
                 board.status_hits[bbc_pkg::ST_UNCLOSED],
                 board.status_hits[bbc_pkg::ST_OVERFLOW]);
        if (board.errors == 0) begin
            $display("[bracket_balance_checker] OK");
        end else begin
            $display("[bracket_balance_checker] ERROR");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_ifs.sv
hw/rtl/bbc_ram.sv
hw/rtl/bbc_front.sv
hw/rtl/bbc_queue.sv
hw/rtl/bbc_back.sv
hw/rtl/bracket_balance_checker.sv
tb/bracket_balance_checker_tb.sv
